// ----- design/ifmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ifmt_pkg: shared types and constants of the integer to ASCII formatter
// Character codes, digit counts and the control and status groups that pass
// between the top level and the digit converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifmt_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int NDIG_W     = 4;
    localparam int CHAR_W     = 7;
    localparam int POS_W      = 16;
    localparam int CNT_W      = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;

    typedef struct packed {
        logic start;
        logic hex_mode;
        logic pop;
    } conv_ctrl_t;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [NDIG_W-1:0] ndig;
    } conv_status_t;

endpackage

`default_nettype wire

// ----- design/ifmt_conv.sv -----
// ----------------------------------------------------------------------------
// ifmt_conv: bit-serial binary to digit converter
// Converts a 32-bit magnitude to decimal digits one bit per cycle with the
// shift-and-add-three method, or loads the hex nibbles directly, then strips
// leading zero digits one digit per cycle. Digits are then popped MSD first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifmt_conv
    import ifmt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire conv_ctrl_t         ctrl,
    input  wire logic [VALUE_W-1:0] mag,
    output conv_status_t            stat,
    output logic [DIGIT_W-1:0]      digit
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_SHIFT = 2'd1;
    localparam logic [1:0] C_NORM  = 2'd2;

    localparam int BITCNT_W = $clog2(VALUE_W);

    logic [1:0]          state_reg, state_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [NDIG_W-1:0]   ndig_reg, ndig_next;
    logic                done_reg, done_next;

    // Each decimal digit of 5 or more gets 3 added before the doubling shift.
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        done_next    = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    if (ctrl.hex_mode)
                    begin
                        bcd_next   = {mag, {(BCD_W - VALUE_W){1'b0}}};
                        ndig_next  = NDIG_W'(HEX_DIGITS);
                        state_next = C_NORM;
                    end
                    else
                    begin
                        bin_next     = mag;
                        bcd_next     = '0;
                        bit_cnt_next = BITCNT_W'(VALUE_W - 1);
                        ndig_next    = NDIG_W'(DEC_DIGITS);
                        state_next   = C_SHIFT;
                    end
                end
                else if (ctrl.pop)
                begin
                    bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
            end
            C_SHIFT:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                    state_next = C_NORM;
            end
            C_NORM:
            begin
                // A zero value keeps one digit.
                if (bcd_reg[BCD_W-1 -: DIGIT_W] == '0 && ndig_reg > NDIG_W'(1))
                begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        ndig_reg    <= ndig_next;
    end

    assign stat.done = done_reg;
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.ndig = ndig_reg;
    assign digit     = bcd_reg[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

// ----- design/integer_to_ascii_formatter_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: printf-style integer to ASCII formatter
// Takes a 32-bit value with a format spec and sends its characters one per
// request, with a last marker on the final character.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_stall) carries the value and its
//   format spec. item_stall is high while an item is being converted or its
//   characters are being produced, so one item is in work at a time.
//   The char channel (char_valid, char_stall) carries one character per
//   request with its position and the last marker.
//   The digit converter works one bit per cycle: a decimal item shifts in
//   every bit of the value and then strips one leading zero digit per step;
//   a hex item loads its nibbles at once and only strips leading zeros.
//   After that one character leaves per cycle while the receiver does not
//   stall. The next item is accepted in the cycle after the last character
//   is registered, while that character may still wait in the output
//   register.
//   When the receiver stalls, the output register holds its character and
//   production pauses; nothing is lost.
//   Reset clears the control state; the block comes up idle and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_top
    import ifmt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      hex_mode,
    input  wire logic                      upper_case,
    input  wire logic                      left_justify,
    input  wire logic                      zero_pad,
    input  wire logic [CNT_W-1:0]          field_width,
    input  wire logic [CNT_W-1:0]          min_digits,
    input  wire logic [POS_W-1:0]          start_pos,
    output logic                           char_valid,
    input  wire logic                      char_stall,
    output logic [CHAR_W-1:0]              char_code,
    output logic [POS_W-1:0]               out_pos,
    output logic                           last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic                upper_reg, upper_next;
    logic                left_reg, left_next;
    logic                zpad_reg, zpad_next;
    logic [CNT_W-1:0]    width_reg, width_next;
    logic [CNT_W-1:0]    prec_reg, prec_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                sfirst_reg, sfirst_next;
    logic                smid_reg, smid_next;
    logic [CNT_W-1:0]    pre_cnt_reg, pre_cnt_next;
    logic [CNT_W-1:0]    post_cnt_reg, post_cnt_next;
    logic [NDIG_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [CHAR_W-1:0]   pad_char_reg, pad_char_next;
    logic                char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic [POS_W-1:0]    opos_reg, opos_next;
    logic                last_reg, last_next;

    logic                item_take;
    logic                slot_free;
    logic                is_neg;
    logic [VALUE_W-1:0]  mag;
    logic [CNT_W-1:0]    total_w;
    logic [CNT_W-1:0]    pad_w;
    logic                zp_w;
    logic [CHAR_W-1:0]   digit_char;
    conv_ctrl_t          conv_ctrl;
    conv_status_t        conv_stat;
    logic [DIGIT_W-1:0]  conv_digit;

    assign item_stall = (state_reg != S_IDLE);
    assign item_take  = item_valid && !item_stall;
    assign slot_free  = !char_valid_reg || !char_stall;

    // Only a decimal negative is printed with a sign; hex shows the raw bits.
    assign is_neg = !hex_mode && value[VALUE_W-1];
    assign mag    = is_neg ? (~value + 1'b1) : value;

    always_comb
    begin
        if (conv_digit < DIGIT_W'(10))
            digit_char = CHAR_ZERO + CHAR_W'(conv_digit);
        else if (upper_reg)
            digit_char = CHAR_UPPER_A + CHAR_W'(conv_digit - DIGIT_W'(10));
        else
            digit_char = CHAR_LOWER_A + CHAR_W'(conv_digit - DIGIT_W'(10));
    end

    // Pad length: a nonzero precision forces zero padding and, when it
    // exceeds the digit count, replaces the width padding.
    always_comb
    begin
        total_w = CNT_W'(conv_stat.ndig) + CNT_W'(neg_reg);
        pad_w   = (width_reg > total_w) ? (width_reg - total_w) : '0;
        zp_w    = zpad_reg || (prec_reg != '0);
        if (prec_reg != '0 && CNT_W'(conv_stat.ndig) < prec_reg)
            pad_w = prec_reg - CNT_W'(conv_stat.ndig);
    end

    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        upper_next      = upper_reg;
        left_next       = left_reg;
        zpad_next       = zpad_reg;
        width_next      = width_reg;
        prec_next       = prec_reg;
        pos_next        = pos_reg;
        sfirst_next     = sfirst_reg;
        smid_next       = smid_reg;
        pre_cnt_next    = pre_cnt_reg;
        post_cnt_next   = post_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        pad_char_next   = pad_char_reg;
        char_valid_next = char_valid_reg;
        char_next       = char_reg;
        opos_next       = opos_reg;
        last_next       = last_reg;
        conv_ctrl.start    = item_take;
        conv_ctrl.hex_mode = hex_mode;
        conv_ctrl.pop      = 1'b0;

        if (slot_free)
            char_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    neg_next   = is_neg;
                    upper_next = upper_case;
                    left_next  = left_justify;
                    zpad_next  = zero_pad;
                    width_next = field_width;
                    prec_next  = min_digits;
                    pos_next   = start_pos;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_stat.done)
                begin
                    // A zero-padded minus sign goes ahead of the pad.
                    sfirst_next   = neg_reg && !left_reg && (pad_w != '0) && zp_w;
                    smid_next     = neg_reg && !(!left_reg && (pad_w != '0) && zp_w);
                    pre_cnt_next  = left_reg ? '0 : pad_w;
                    post_cnt_next = left_reg ? pad_w : '0;
                    dig_cnt_next  = conv_stat.ndig;
                    pad_char_next = zp_w ? CHAR_ZERO : CHAR_SPACE;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    char_valid_next = 1'b1;
                    opos_next       = pos_reg;
                    pos_next        = pos_reg + 1'b1;
                    last_next       = 1'b0;
                    if (sfirst_reg)
                    begin
                        char_next   = CHAR_MINUS;
                        sfirst_next = 1'b0;
                    end
                    else if (pre_cnt_reg != '0)
                    begin
                        char_next    = pad_char_reg;
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end
                    else if (smid_reg)
                    begin
                        char_next = CHAR_MINUS;
                        smid_next = 1'b0;
                    end
                    else if (dig_cnt_reg != '0)
                    begin
                        char_next     = digit_char;
                        conv_ctrl.pop = 1'b1;
                        dig_cnt_next  = dig_cnt_reg - 1'b1;
                        last_next     = (dig_cnt_reg == NDIG_W'(1)) && (post_cnt_reg == '0);
                    end
                    else
                    begin
                        char_next     = CHAR_SPACE;
                        post_cnt_next = post_cnt_reg - 1'b1;
                        last_next     = (post_cnt_reg == CNT_W'(1));
                    end
                    if (last_next)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            char_valid_reg <= 1'b0;
            sfirst_reg     <= 1'b0;
            smid_reg       <= 1'b0;
            pre_cnt_reg    <= '0;
            post_cnt_reg   <= '0;
            dig_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
            sfirst_reg     <= sfirst_next;
            smid_reg       <= smid_next;
            pre_cnt_reg    <= pre_cnt_next;
            post_cnt_reg   <= post_cnt_next;
            dig_cnt_reg    <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        upper_reg    <= upper_next;
        left_reg     <= left_next;
        zpad_reg     <= zpad_next;
        width_reg    <= width_next;
        prec_reg     <= prec_next;
        pos_reg      <= pos_next;
        pad_char_reg <= pad_char_next;
        char_reg     <= char_next;
        opos_reg     <= opos_next;
        last_reg     <= last_next;
    end

    ifmt_conv u_conv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (conv_ctrl),
        .mag   (mag),
        .stat  (conv_stat),
        .digit (conv_digit)
    );

    assign char_valid = char_valid_reg;
    assign char_code  = char_reg;
    assign out_pos    = opos_reg;
    assign last       = last_reg;

    // The converter only runs while an item is in conversion.
    a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.busy |-> state_reg == S_CONV)
        else $error("digit converter busy outside conversion");

    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> state_reg == S_CONV)
        else $error("conversion finished while not waiting for it");

    // Emission starts with between one and ten digits pending.
    a_emit_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && $past(state_reg) == S_CONV)
        |-> (dig_cnt_reg != '0 && dig_cnt_reg <= NDIG_W'(DEC_DIGITS)))
        else $error("bad digit count at start of emission");

    // A new item only enters once every character of the last one has been produced.
    a_take_clean: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> (dig_cnt_reg == '0 && post_cnt_reg == '0 && pre_cnt_reg == '0))
        else $error("item accepted with characters still pending");

endmodule

`default_nettype wire
